// ===== rtl/uap_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the URL authority parser.
// No dependencies; imported by uap_decode and url_authority_parser.
package uap_pkg;

  localparam int unsigned PROTO_LIMIT_DEF = 16;
  localparam int unsigned HOST_LIMIT_DEF  = 256;
  localparam int unsigned PATH_LIMIT_DEF  = 256;

  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharLbr   = 8'h5B;
  localparam logic [7:0] CharRbr   = 8'h5D;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [15:0] PortMax = 16'hFFFF;

  typedef enum logic [1:0] {
    TagDrop  = 2'd0,
    TagProto = 2'd1,
    TagHost  = 2'd2,
    TagPath  = 2'd3
  } field_tag_e;

  typedef enum logic [1:0] {
    StatFail = 2'd0,
    StatName = 2'd1,
    StatIpv4 = 2'd2,
    StatIpv6 = 2'd3
  } parse_status_e;

  // Classification of one character.
  typedef struct packed {
    logic       is_digit;
    logic       is_dot;
    logic       is_colon;
    logic       is_slash;
    logic       is_lbr;
    logic       is_rbr;
    logic [3:0] digit;
  } char_class_t;

endpackage

// ===== rtl/url_authority_parser.sv =====
`timescale 1ns / 1ps
// URL authority parser top level: byte stream in, tagged byte stream out.
// Depends on uap_pkg and uap_decode.
//
// Usage:
//   The slave channel takes one URL character per word in s_axis_tdata_i,
//   with s_axis_tlast_i set on the final character of the URL.
//   The master channel returns one word per input word: the character
//   echoed, a field tag in m_axis_tuser_o (dropped, protocol, host, path),
//   and on the final word (m_axis_tlast_o high) the parse status and port.
//   On other words status and port read as zero.
// Throughput and timing:
//   One word per cycle while the output is not stalled. A result appears in
//   the cycle after its input word is taken; the single per-character state
//   update and the output register are the only sequential elements in the path.
// Reset:
//   rst_ni clears the parser to the protocol phase and empties the output
//   register. The parser also returns to that state after every final word.
// Stall:
//   While the output word waits for m_axis_tready_i, s_axis_tready_o drops
//   and the output register holds; it reopens in the cycle the word leaves.
module url_authority_parser
  import uap_pkg::*;
#(
  parameter int unsigned PROTO_LIMIT = PROTO_LIMIT_DEF,
  parameter int unsigned HOST_LIMIT  = HOST_LIMIT_DEF,
  parameter int unsigned PATH_LIMIT  = PATH_LIMIT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_byte
  input  logic        s_axis_tlast_i,   // last_char
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] byte_out, [9:8] parse_status,
                                        // [25:10] port_number, [31:26] zero
  output logic [1:0]  m_axis_tuser_o,   // [1:0] field_tag
  output logic        m_axis_tlast_o    // parse_done
);

  typedef enum logic [3:0] {
    PhProto  = 4'd0,
    PhSlash1 = 4'd1,
    PhSlash2 = 4'd2,
    PhHstart = 4'd3,
    PhHost   = 4'd4,
    PhV6     = 4'd5,
    PhAfter  = 4'd6,
    PhPstart = 4'd7,
    PhPort   = 4'd8,
    PhPath   = 4'd9,
    PhDrop   = 4'd10
  } phase_e;

  localparam logic [9:0] ProtoLim   = 10'(PROTO_LIMIT);
  localparam logic [8:0] HostLim    = 9'(HOST_LIMIT);
  localparam logic [8:0] PathTagLim = 9'(PATH_LIMIT - 2);

  // Parser state
  phase_e      phase_q, phase_d;
  logic [8:0]  cnt_q, cnt_d;
  logic [15:0] port_q, port_d;
  logic        numeric_q, numeric_d;
  logic        bracket_q, bracket_d;
  logic        fail_q, fail_d;

  // Output register
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  field_tag_e  out_tag_q;
  logic        out_last_q;
  parse_status_e out_stat_q;
  logic [15:0] out_port_q;

  logic        accept;
  char_class_t cls;
  logic [15:0] port_next;
  field_tag_e  tag;
  parse_status_e stat;
  logic [15:0] port_out;
  logic        do_host_char;
  logic        do_host_end;
  logic        do_start_path;

  // Accept whenever the output register is empty or draining this cycle.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  uap_decode u_decode (
    .char_i      (s_axis_tdata_i),
    .port_i      (port_q),
    .cls_o       (cls),
    .port_next_o (port_next)
  );

  always_comb begin
    phase_d       = phase_q;
    cnt_d         = cnt_q;
    port_d        = port_q;
    numeric_d     = numeric_q;
    bracket_d     = bracket_q;
    fail_d        = fail_q;
    tag           = TagDrop;
    stat          = StatFail;
    port_out      = 16'd0;
    do_host_char  = 1'b0;
    do_host_end   = 1'b0;
    do_start_path = 1'b0;

    if (!fail_q) begin
      case (phase_q)
        PhProto: begin
          if (cls.is_colon) begin
            phase_d = PhSlash1;
            cnt_d   = 9'd0;
          end else if ({1'b0, cnt_q} + 10'd1 >= ProtoLim) begin
            fail_d = 1'b1;
          end else begin
            cnt_d = cnt_q + 9'd1;
            tag   = TagProto;
          end
        end
        PhSlash1: begin
          if (cls.is_slash) phase_d = PhSlash2;
          else              fail_d  = 1'b1;
        end
        PhSlash2: begin
          if (cls.is_slash) phase_d = PhHstart;
          else              fail_d  = 1'b1;
        end
        PhHstart: begin
          if (cls.is_lbr) begin
            bracket_d = 1'b1;
            phase_d   = PhV6;
          end else if (cls.is_colon || cls.is_slash) begin
            do_host_end = 1'b1;
          end else begin
            phase_d      = PhHost;
            do_host_char = 1'b1;
          end
        end
        PhHost: begin
          if (cls.is_colon || cls.is_slash) do_host_end  = 1'b1;
          else                              do_host_char = 1'b1;
        end
        PhV6: begin
          if (cls.is_rbr) begin
            if (cnt_q == 9'd0) fail_d  = 1'b1;
            else               phase_d = PhAfter;
          end else begin
            do_host_char = 1'b1;
          end
        end
        PhAfter: do_host_end = 1'b1;
        PhPstart: begin
          if (cls.is_digit) begin
            port_d  = {12'd0, cls.digit};
            phase_d = PhPort;
          end else begin
            fail_d = 1'b1;
          end
        end
        PhPort: begin
          if (cls.is_digit)      port_d        = port_next;
          else if (cls.is_slash) do_start_path = 1'b1;
          else                   phase_d       = PhDrop;
        end
        PhPath: begin
          if (cnt_q < PathTagLim) begin
            cnt_d = cnt_q + 9'd1;
            tag   = TagPath;
          end
        end
        default: ;
      endcase
    end

    // Host character: count it, fail past the length limit.
    if (do_host_char) begin
      if (cnt_q >= HostLim) begin
        fail_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 9'd1;
        tag   = TagHost;
        if (!cls.is_digit && !cls.is_dot) numeric_d = 1'b0;
      end
    end

    // End of host: an empty host fails, else branch on the separator.
    if (do_host_end) begin
      if (cnt_q == 9'd0)      fail_d        = 1'b1;
      else if (cls.is_colon)  phase_d       = PhPstart;
      else if (cls.is_slash)  do_start_path = 1'b1;
      else                    phase_d       = PhDrop;
    end

    // The leading slash belongs to the path.
    if (do_start_path) begin
      phase_d = PhPath;
      cnt_d   = 9'd1;
      tag     = TagPath;
    end

    // Final character: report, then go back to the reset state.
    if (s_axis_tlast_i) begin
      if (!fail_d && (phase_d == PhHost || phase_d == PhAfter || phase_d == PhPort ||
                      phase_d == PhPath || phase_d == PhDrop)) begin
        if (bracket_d)      stat = StatIpv6;
        else if (numeric_d) stat = StatIpv4;
        else                stat = StatName;
        port_out = port_d;
      end
      phase_d   = PhProto;
      cnt_d     = 9'd0;
      port_d    = 16'd0;
      numeric_d = 1'b1;
      bracket_d = 1'b0;
      fail_d    = 1'b0;
    end
  end

  // Advance parser state on each accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhProto;
      cnt_q     <= 9'd0;
      port_q    <= 16'd0;
      numeric_q <= 1'b1;
      bracket_q <= 1'b0;
      fail_q    <= 1'b0;
    end else if (accept) begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      port_q    <= port_d;
      numeric_q <= numeric_d;
      bracket_q <= bracket_d;
      fail_q    <= fail_d;
    end
  end

  // Output register: load on accept, drop valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_byte_q <= s_axis_tdata_i;
      out_tag_q  <= tag;
      out_last_q <= s_axis_tlast_i;
      out_stat_q <= stat;
      out_port_q <= port_out;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_port_q, out_stat_q, out_byte_q};
  assign m_axis_tuser_o  = out_tag_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== rtl/uap_decode.sv =====
`timescale 1ns / 1ps
// Character classifier and saturating decimal port accumulator.
// Depends on uap_pkg.
module uap_decode
  import uap_pkg::*;
(
  input  logic [7:0]  char_i,
  input  logic [15:0] port_i,
  output char_class_t cls_o,
  output logic [15:0] port_next_o
);

  logic [7:0]  diff;
  logic [19:0] times_ten;

  assign diff = char_i - CharZero;

  always_comb begin
    cls_o.is_digit = (char_i >= CharZero) && (char_i <= CharNine);
    cls_o.is_dot   = (char_i == CharDot);
    cls_o.is_colon = (char_i == CharColon);
    cls_o.is_slash = (char_i == CharSlash);
    cls_o.is_lbr   = (char_i == CharLbr);
    cls_o.is_rbr   = (char_i == CharRbr);
    cls_o.digit    = diff[3:0];
  end

  // port * 10 + digit, clamped to the 16-bit maximum
  assign times_ten = ({4'd0, port_i} << 3) + ({4'd0, port_i} << 1) + {16'd0, diff[3:0]};
  assign port_next_o = (times_ten > {4'd0, PortMax}) ? PortMax : times_ten[15:0];

endmodule

// ===== tb/sv/tb_url_authority_parser.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for url_authority_parser: streams URLs byte by byte,
// predicts every tagged output word and checks it. Depends on uap_pkg and the RTL.

module tb_url_authority_parser;
  import uap_pkg::*;

  localparam int StallLimit = 2000;  // cycles with no word moving before giving up

  // Parser phases of the predictor, in the order a well-formed URL visits them.
  typedef enum logic [3:0] {
    PhProto, PhSlash1, PhSlash2, PhHstart, PhHost, PhV6,
    PhAfter, PhPstart, PhPort, PhPath, PhDrop
  } url_phase_e;

  // One expected output word.
  typedef struct {
    logic [7:0]    ch;
    field_tag_e    tag;
    logic          done;
    parse_status_e status;
    logic [15:0]   port;
  } url_word_t;

  // Scoreboard: runs the parser prediction on every accepted input word and
  // compares each output word against the oldest prediction.
  class url_scoreboard;
    url_phase_e  phase;
    int          count;
    int unsigned port_acc;
    bit          numeric;
    bit          bracketed;
    bit          failed;
    url_word_t   expected_q[$];
    int          mismatches;
    int          words_checked;
    int          urls_done;
    int          status_seen[4];

    function new();
      clear_state();
    endfunction

    function void clear_state();
      phase     = PhProto;
      count     = 0;
      port_acc  = 0;
      numeric   = 1'b1;
      bracketed = 1'b0;
      failed    = 1'b0;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CharZero && c <= CharNine;
    endfunction

    function field_tag_e take_host_char(logic [7:0] c);
      if (count >= HOST_LIMIT_DEF) begin
        failed = 1'b1;
        return TagDrop;
      end
      count++;
      if (!is_digit(c) && c != CharDot) numeric = 1'b0;
      return TagHost;
    endfunction

    function field_tag_e begin_path();
      phase = PhPath;
      count = 1;
      return TagPath;
    endfunction

    // Host finished: an empty host fails, else colon opens a port, slash opens the path, anything else ends it.
    function field_tag_e end_of_host(logic [7:0] c);
      if (count == 0) begin
        failed = 1'b1;
        return TagDrop;
      end
      if (c == CharColon) begin
        phase = PhPstart;
        return TagDrop;
      end
      if (c == CharSlash) return begin_path();
      phase = PhDrop;
      return TagDrop;
    endfunction

    function void note_char(logic [7:0] c, logic last);
      url_word_t w;
      w.ch     = c;
      w.tag    = TagDrop;
      w.done   = last;
      w.status = StatFail;
      w.port   = '0;
      if (!failed) begin
        case (phase)
          PhProto: begin
            if (c == CharColon) begin
              phase = PhSlash1;
              count = 0;
            end else if (count + 1 >= PROTO_LIMIT_DEF) begin
              failed = 1'b1;
            end else begin
              count++;
              w.tag = TagProto;
            end
          end
          PhSlash1: begin
            if (c == CharSlash) phase = PhSlash2;
            else failed = 1'b1;
          end
          PhSlash2: begin
            if (c == CharSlash) phase = PhHstart;
            else failed = 1'b1;
          end
          PhHstart: begin
            if (c == CharLbr) begin
              bracketed = 1'b1;
              phase = PhV6;
            end else if (c == CharColon || c == CharSlash) begin
              w.tag = end_of_host(c);
            end else begin
              phase = PhHost;
              w.tag = take_host_char(c);
            end
          end
          PhHost: begin
            if (c == CharColon || c == CharSlash) w.tag = end_of_host(c);
            else w.tag = take_host_char(c);
          end
          PhV6: begin
            if (c == CharRbr) begin
              if (count == 0) failed = 1'b1;
              else phase = PhAfter;
            end else begin
              w.tag = take_host_char(c);
            end
          end
          PhAfter: w.tag = end_of_host(c);
          PhPstart: begin
            if (is_digit(c)) begin
              port_acc = c - CharZero;
              phase = PhPort;
            end else begin
              failed = 1'b1;
            end
          end
          PhPort: begin
            if (is_digit(c)) begin
              port_acc = port_acc * 10 + (c - CharZero);
              if (port_acc > PortMax) port_acc = PortMax;
            end else if (c == CharSlash) begin
              w.tag = begin_path();
            end else begin
              phase = PhDrop;
            end
          end
          PhPath: begin
            if (count < PATH_LIMIT_DEF - 2) begin
              count++;
              w.tag = TagPath;
            end
          end
          default: ;
        endcase
      end
      if (last) begin
        if (!failed) begin
          case (phase)
            PhHost, PhAfter, PhPort, PhPath, PhDrop: begin
              if (bracketed) w.status = StatIpv6;
              else if (numeric) w.status = StatIpv4;
              else w.status = StatName;
              w.port = port_acc[15:0];
            end
            default: ;
          endcase
        end
        status_seen[w.status]++;
        urls_done++;
        clear_state();
      end
      expected_q.push_back(w);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_word(logic [31:0] data, logic [1:0] user, logic last);
      url_word_t w;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, actual data %0h tag %0h last %0b",
                 $time, data, user, last);
        return;
      end
      w = expected_q.pop_front();
      words_checked++;
      compare_field("byte_out",     w.ch,     data[7:0]);
      compare_field("field_tag",    w.tag,    user);
      compare_field("parse_done",   w.done,   last);
      compare_field("parse_status", w.status, data[9:8]);
      compare_field("port_number",  w.port,   data[25:10]);
      compare_field("pad bits",     '0,       data[31:26]);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;   // [7:0] char_byte
  logic        s_axis_tlast_i  = 1'b0; // last_char
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;         // [7:0] byte_out, [9:8] parse_status,
                                       // [25:10] port_number, [31:26] zero
  logic [1:0]  m_axis_tuser_o;         // [1:0] field_tag
  logic        m_axis_tlast_o;         // parse_done

  url_authority_parser u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  url_scoreboard sb = new();
  logic [7:0]    url_buf[$];   // URL being assembled for sending
  bit            idle_en = 1'b1;
  int            items_sent;
  int            stall_left;
  int            quiet_cycles;

  // ---------------------------------------------------------------------------
  // Output side: random backpressure bursts while idle_en is set, otherwise always ready.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left      <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left      <= $urandom_range(0, 16);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Check every output word as it leaves; the watchdog trips when neither
  // side has moved a word while quiet_cycles counts up to StallLimit.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_word(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == StallLimit) begin
        $display("%0t: watchdog, no word moved for %0d cycles, %0d still expected",
                 $time, StallLimit, sb.pending());
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Present one word, hold it until taken, then note it for prediction.
  // A random gap, taken only while idle_en is set, drops tvalid before raising it again.
  task automatic send_char(input logic [7:0] c, input logic last);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_char(c, last);
    items_sent++;
  endtask

  task automatic send_url();
    for (int i = 0; i < url_buf.size(); i++)
      send_char(url_buf[i], i == url_buf.size() - 1);
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) url_buf.push_back(s[i]);
  endfunction

  task automatic send_text(string s);
    url_buf.delete();
    push_text(s);
    send_url();
  endtask

  function automatic void push_run(logic [7:0] c, int n);
    repeat (n) url_buf.push_back(c);
  endfunction

  function automatic void push_noise(int n);
    repeat (n) url_buf.push_back(8'($urandom_range(1, 255)));
  endfunction

  function automatic logic [7:0] any_char_but(logic [7:0] a, logic [7:0] b);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == a || c == b);
    return c;
  endfunction

  // Character that is neither a separator nor a digit: ends a bracketed host or a port.
  function automatic logic [7:0] junk_char();
    if ($urandom_range(0, 1) != 0) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(97, 122));
  endfunction

  function automatic logic [7:0] digit_char();
    return CharZero + 8'($urandom_range(0, 9));
  endfunction

  // Protocol or host-name character: never a colon or slash.
  function automatic logic [7:0] name_char();
    case ($urandom_range(0, 5))
      0:       return any_char_but(CharColon, CharSlash);
      1:       return digit_char();
      2:       return CharDot;
      default: return 8'($urandom_range(97, 122));
    endcase
  endfunction

  // Assemble one random URL: mostly well-formed with random content, with
  // broken separators, empty hosts, missing brackets, bare port colons,
  // trailing junk, cuts at any point and pure noise mixed in.
  function automatic void make_random_url();
    int plen, hlen, hkind, n;
    url_buf.delete();
    if ($urandom_range(0, 15) == 0) begin
      push_noise($urandom_range(1, 12));
      return;
    end
    plen = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 18) : $urandom_range(0, 6);
    repeat (plen) url_buf.push_back(name_char());
    case ($urandom_range(0, 11))
      0: begin
        url_buf.push_back(CharColon);
        url_buf.push_back(junk_char());
      end
      1: begin
        push_text(":/");
        url_buf.push_back(junk_char());
      end
      default: push_text("://");
    endcase
    hlen  = ($urandom_range(0, 24) == 0) ? $urandom_range(254, 258) : $urandom_range(1, 10);
    hkind = $urandom_range(0, 9);
    if (hkind <= 3) begin
      repeat (hlen) url_buf.push_back(name_char());
    end else if (hkind <= 5) begin
      repeat (hlen) url_buf.push_back(($urandom_range(0, 3) == 0) ? CharDot : digit_char());
    end else if (hkind <= 7) begin
      url_buf.push_back(CharLbr);
      if ($urandom_range(0, 5) == 0) hlen = 0;
      repeat (hlen)
        url_buf.push_back(($urandom_range(0, 2) == 0) ? CharColon : any_char_but(CharRbr, CharRbr));
      if ($urandom_range(0, 5) == 0) return;  // URL ends inside the brackets
      url_buf.push_back(CharRbr);
      if ($urandom_range(0, 7) == 0) url_buf.push_back(junk_char());
    end
    // hkind 8 and 9 leave the host empty
    if ($urandom_range(0, 1) != 0) begin
      url_buf.push_back(CharColon);
      n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 7);
      repeat (n) url_buf.push_back(digit_char());
      if ($urandom_range(0, 9) == 0) url_buf.push_back(junk_char());
    end
    if ($urandom_range(0, 1) != 0) begin
      url_buf.push_back(CharSlash);
      push_noise(($urandom_range(0, 24) == 0) ? $urandom_range(250, 258) : $urandom_range(0, 8));
    end
    if ($urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, url_buf.size());
      while (url_buf.size() > n) void'(url_buf.pop_back());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Short directed URLs: empty brackets, IPv6 with trailing junk,
    // IPv4 with a saturating port and a bare path, extreme byte values.
    send_text("a://[]");
    send_text("b://[::1]z");
    send_text("c://9.0:99999/");
    url_buf = '{8'hFF, 8'h01};
    send_url();

    // Length limits: protocol just under and at its limit, a full host
    // followed by a port and a path that runs past its tagged length,
    // and one host character too many.
    url_buf.delete();
    push_run("p", PROTO_LIMIT_DEF - 1);
    push_text("://h");
    send_url();
    url_buf.delete();
    push_run("q", PROTO_LIMIT_DEF);
    push_text("://h");
    send_url();
    url_buf.delete();
    push_text("h://");
    push_run("a", HOST_LIMIT_DEF);
    push_text(":80/");
    push_run("x", PATH_LIMIT_DEF - 1);
    send_url();
    url_buf.delete();
    push_text("n://");
    push_run("7", HOST_LIMIT_DEF + 1);
    send_url();

    // Random URLs up to the word budget; the last stretch runs with no gaps
    // and no backpressure.
    while (items_sent < 1000) begin
      if (items_sent > 920) idle_en = 1'b0;
      make_random_url();
      send_url();
    end
    s_axis_tvalid_i <= 1'b0;

    // Drain, then give the block a few more cycles to show any stray word.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Sent %0d URLs in %0d words, checked %0d output words.",
             sb.urls_done, items_sent, sb.words_checked);
    $display("Outcomes: %0d failed, %0d hostname, %0d IPv4, %0d IPv6; %0d mismatches.",
             sb.status_seen[StatFail], sb.status_seen[StatName],
             sb.status_seen[StatIpv4], sb.status_seen[StatIpv6], sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
